// ----- sv/psq_pkg.sv -----
package psq_pkg;

    localparam int NUM_SEMS_DEF        = 2;
    localparam int PRIORITY_LEVELS_DEF = 4;
    localparam int PROCESS_SLOTS_DEF   = 32;
    localparam int COUNT_BITS_DEF      = 16;

    localparam logic [1:0] REQ_WAIT   = 2'd0;
    localparam logic [1:0] REQ_SIGNAL = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    typedef struct packed {
        logic load;
        logic decide;
        logic link;
        logic unlink;
        logic emit;
    } psq_cmd_t;

    typedef struct packed {
        logic need_link;
        logic need_unlink;
        logic out_free;
    } psq_sts_t;

endpackage

// ----- sv/psq_ctrl.sv -----
module psq_ctrl
    import psq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  psq_sts_t sts,
    output psq_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_LINK   = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_UNLINK = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                if (sts.need_link)
                begin
                    state_next = S_LINK;
                end
                else if (sts.need_unlink)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_OUT;
            end
            S_RD:
            begin
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/psq_datapath.sv -----
module psq_datapath
    import psq_pkg::*;
#(
    parameter int NUM_SEMS        = NUM_SEMS_DEF,
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
    parameter int PROCESS_SLOTS   = PROCESS_SLOTS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  psq_cmd_t   cmd,
    output psq_sts_t   sts,
    input  logic [1:0] req_type,
    input  logic [7:0] sem_index,
    input  logic [4:0] pid,
    input  logic [1:0] priority_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       woken_valid,
    output logic [4:0] woken_pid
);

    localparam int QUEUES = NUM_SEMS * PRIORITY_LEVELS;
    localparam int SLOT_W = $clog2(PROCESS_SLOTS + 1);
    localparam int PID_W  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int Q_W    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [SLOT_W-1:0] NIL = SLOT_W'(PROCESS_SLOTS);

    logic [1:0] req_reg;
    logic [7:0] sem_reg;
    logic [4:0] pid_reg;
    logic [1:0] lvl_reg;

    logic [COUNT_BITS-1:0] count_reg [NUM_SEMS];
    logic [SLOT_W-1:0]     head_reg  [QUEUES];
    logic [SLOT_W-1:0]     tail_reg  [QUEUES];
    logic                  wait_reg  [PROCESS_SLOTS];
    logic [SEM_W-1:0]      wsem_reg  [PROCESS_SLOTS];
    logic [LVL_W-1:0]      wlvl_reg  [PROCESS_SLOTS];

    logic [SLOT_W-1:0] next_mem [PROCESS_SLOTS];
    logic [SLOT_W-1:0] prev_mem [PROCESS_SLOTS];
    logic [SLOT_W-1:0] next_rd_reg;
    logic [SLOT_W-1:0] prev_rd_reg;

    logic [Q_W-1:0]    q_reg;
    logic [SLOT_W-1:0] t_reg;
    logic [1:0]        res_status_reg;
    logic              res_wv_reg;
    logic [4:0]        res_wp_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic              out_wv_reg;
    logic [4:0]        out_wp_reg;

    logic              sem_ok;
    logic              pid_ok;
    logic              lvl_ok;
    logic [SEM_W-1:0]  sem_i;
    logic [PID_W-1:0]  pid_i;
    logic [LVL_W-1:0]  lvl_i;
    logic [Q_W-1:0]    q_wait;
    logic [Q_W-1:0]    q_sig;
    logic              found;
    logic [SLOT_W-1:0] found_head;
    logic [SLOT_W-1:0] t_wait;
    logic [PID_W-1:0]  p_sel;
    logic [Q_W-1:0]    q_unl;
    logic [1:0]        dec_status;
    logic              dec_wv;
    logic              do_dec;
    logic              do_inc;
    logic              do_enq;
    logic              do_unl;

    logic              nx_we;
    logic [PID_W-1:0]  nx_wa;
    logic [SLOT_W-1:0] nx_wd;
    logic              pv_we;
    logic [PID_W-1:0]  pv_wa;
    logic [SLOT_W-1:0] pv_wd;

    assign sem_ok = (32'(sem_reg) < NUM_SEMS);
    assign pid_ok = (32'(pid_reg) < PROCESS_SLOTS);
    assign lvl_ok = (32'(lvl_reg) < PRIORITY_LEVELS);
    assign sem_i  = SEM_W'(sem_reg);
    assign pid_i  = PID_W'(pid_reg);
    assign lvl_i  = LVL_W'(lvl_reg);
    assign q_wait = Q_W'(int'(sem_i) * PRIORITY_LEVELS + int'(lvl_i));
    assign t_wait = tail_reg[q_wait];

    always_comb
    begin
        found      = 1'b0;
        found_head = NIL;
        q_sig      = '0;
        for (int l = 0; l < PRIORITY_LEVELS; l++)
        begin
            if (head_reg[Q_W'(int'(sem_i) * PRIORITY_LEVELS + l)] != NIL)
            begin
                found      = 1'b1;
                q_sig      = Q_W'(int'(sem_i) * PRIORITY_LEVELS + l);
                found_head = head_reg[q_sig];
            end
        end
    end

    always_comb
    begin
        dec_status = ST_FAIL;
        dec_wv     = 1'b0;
        do_dec     = 1'b0;
        do_inc     = 1'b0;
        do_enq     = 1'b0;
        do_unl     = 1'b0;
        p_sel      = pid_i;
        case (req_reg)
            REQ_WAIT:
            begin
                if (sem_ok && pid_ok && lvl_ok && !wait_reg[pid_i])
                begin
                    if (count_reg[sem_i] != '0)
                    begin
                        do_dec     = 1'b1;
                        dec_status = ST_OK;
                    end
                    else
                    begin
                        do_enq     = 1'b1;
                        dec_status = ST_BLOCKED;
                    end
                end
            end
            REQ_SIGNAL:
            begin
                if (sem_ok)
                begin
                    dec_status = ST_OK;
                    if (found)
                    begin
                        do_unl = 1'b1;
                        dec_wv = 1'b1;
                        p_sel  = PID_W'(found_head);
                    end
                    else
                    begin
                        do_inc = ~&count_reg[sem_i];
                    end
                end
            end
            REQ_CANCEL:
            begin
                if (pid_ok && wait_reg[pid_i])
                begin
                    do_unl     = 1'b1;
                    dec_status = ST_OK;
                end
            end
            default:
            begin
                dec_status = ST_FAIL;
            end
        endcase
    end

    assign q_unl = Q_W'(int'(wsem_reg[p_sel]) * PRIORITY_LEVELS + int'(wlvl_reg[p_sel]));

    assign sts.need_link   = do_enq && (t_wait != NIL);
    assign sts.need_unlink = do_unl;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    always_comb
    begin
        nx_we = 1'b0;
        nx_wa = pid_i;
        nx_wd = NIL;
        pv_we = 1'b0;
        pv_wa = pid_i;
        pv_wd = t_wait;
        if (cmd.decide && do_enq)
        begin
            nx_we = 1'b1;
            pv_we = 1'b1;
        end
        else if (cmd.link)
        begin
            nx_we = 1'b1;
            nx_wa = PID_W'(t_reg);
            nx_wd = SLOT_W'(pid_i);
        end
        else if (cmd.unlink)
        begin
            nx_we = (prev_rd_reg != NIL);
            nx_wa = PID_W'(prev_rd_reg);
            nx_wd = next_rd_reg;
            pv_we = (next_rd_reg != NIL);
            pv_wa = PID_W'(next_rd_reg);
            pv_wd = prev_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (cmd.decide)
        begin
            next_rd_reg <= next_mem[p_sel];
            prev_rd_reg <= prev_mem[p_sel];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            sem_reg <= sem_index;
            pid_reg <= pid;
            lvl_reg <= priority_req;
        end
        if (cmd.decide)
        begin
            q_reg          <= q_unl;
            t_reg          <= t_wait;
            res_status_reg <= dec_status;
            res_wv_reg     <= dec_wv;
            res_wp_reg     <= dec_wv ? 5'(p_sel) : 5'd0;
            if (do_enq)
            begin
                wsem_reg[pid_i] <= sem_i;
                wlvl_reg[pid_i] <= lvl_i;
            end
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_wv_reg     <= res_wv_reg;
            out_wp_reg     <= res_wp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_SEMS; s++)
            begin
                count_reg[s] <= '0;
            end
            for (int q = 0; q < QUEUES; q++)
            begin
                head_reg[q] <= NIL;
                tail_reg[q] <= NIL;
            end
            for (int p = 0; p < PROCESS_SLOTS; p++)
            begin
                wait_reg[p] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.decide)
            begin
                if (do_dec)
                begin
                    count_reg[sem_i] <= count_reg[sem_i] - 1'b1;
                end
                if (do_inc)
                begin
                    count_reg[sem_i] <= count_reg[sem_i] + 1'b1;
                end
                if (do_enq)
                begin
                    wait_reg[pid_i]  <= 1'b1;
                    tail_reg[q_wait] <= SLOT_W'(pid_i);
                    if (t_wait == NIL)
                    begin
                        head_reg[q_wait] <= SLOT_W'(pid_i);
                    end
                end
                if (do_unl)
                begin
                    wait_reg[p_sel] <= 1'b0;
                end
            end
            if (cmd.unlink)
            begin
                if (prev_rd_reg == NIL)
                begin
                    head_reg[q_reg] <= next_rd_reg;
                end
                if (next_rd_reg == NIL)
                begin
                    tail_reg[q_reg] <= prev_rd_reg;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign woken_valid = out_wv_reg;
    assign woken_pid   = out_wp_reg;

endmodule

// ----- sv/priority_semaphore_wait_queues.sv -----
// Channel   Handshake              Beat contents
// input     in_valid / in_stall    req_type, sem_index, pid, priority_req
// output    out_valid / out_stall  status, woken_valid, woken_pid
//
// A request is loaded and decided, then a wait that joins behind an existing tail
// links, or a signal or cancel that unlinks a slot reads its links and unlinks.
// Reset is asynchronous and clears counts, queue heads and tails and wait flags.
// A new beat is taken once the previous result is in the output register, and a
// stalled output holds back the following result and, until it is delivered, new beats.
module priority_semaphore_wait_queues
    import psq_pkg::*;
#(
    parameter int NUM_SEMS        = NUM_SEMS_DEF,
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
    parameter int PROCESS_SLOTS   = PROCESS_SLOTS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] sem_index,
    input  logic [4:0] pid,
    input  logic [1:0] priority_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       woken_valid,
    output logic [4:0] woken_pid
);

    psq_cmd_t cmd;
    psq_sts_t sts;

    psq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    psq_datapath #(
        .NUM_SEMS        (NUM_SEMS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .PROCESS_SLOTS   (PROCESS_SLOTS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .sem_index    (sem_index),
        .pid          (pid),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .woken_valid  (woken_valid),
        .woken_pid    (woken_pid)
    );

endmodule

// ----- bench/priority_semaphore_wait_queues_test.sv -----
module priority_semaphore_wait_queues_test;
    import psq_pkg::*;

    localparam int NSEM = NUM_SEMS_DEF;
    localparam int NLVL = PRIORITY_LEVELS_DEF;
    localparam int NSLOT = PROCESS_SLOTS_DEF;
    localparam int NQ = NSEM * NLVL;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;
    localparam logic [5:0] NIL = 6'(NSLOT);
    localparam logic [1:0] REQ_BAD = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] sem_index;
        logic [4:0] pid;
        logic [1:0] priority_req;
    } sem_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       woken_valid;
        logic [4:0] woken_pid;
    } sem_resp_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic [7:0] sem_index;
    logic [4:0] pid;
    logic [1:0] priority_req;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic woken_valid;
    logic [4:0] woken_pid;

    logic [15:0] count_m [NSEM];
    logic [5:0] head_m [NQ];
    logic [5:0] tail_m [NQ];
    logic [5:0] next_m [NSLOT];
    logic [5:0] prev_m [NSLOT];
    logic waiting_m [NSLOT];
    int sem_of [NSLOT];
    int lvl_of [NSLOT];

    sem_req_t pending_reqs[$];
    sem_resp_t expected_resps[$];
    bit failed;
    bit hold_off;
    logic in_fire;
    int in_gap;
    int out_gap;
    int idle_cycles;

    priority_semaphore_wait_queues dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void unlink_waiter(int p);
        int q;
        q = sem_of[p] * NLVL + lvl_of[p];
        if (prev_m[p] == NIL) head_m[q] = next_m[p];
        else next_m[prev_m[p]] = next_m[p];
        if (next_m[p] == NIL) tail_m[q] = prev_m[p];
        else prev_m[next_m[p]] = prev_m[p];
        waiting_m[p] = 1'b0;
    endfunction

    function automatic sem_resp_t predict_semaphore(sem_req_t r);
        sem_resp_t res;
        int q;
        res = '{status: ST_FAIL, woken_valid: 1'b0, woken_pid: 5'd0};
        if (r.req_type == REQ_WAIT)
        begin
            if (r.sem_index < NSEM && r.pid < NSLOT && r.priority_req < NLVL
                && !waiting_m[r.pid])
            begin
                if (count_m[r.sem_index] != 0)
                begin
                    count_m[r.sem_index]--;
                    res.status = ST_OK;
                end
                else
                begin
                    q = r.sem_index * NLVL + r.priority_req;
                    next_m[r.pid] = NIL;
                    prev_m[r.pid] = tail_m[q];
                    if (tail_m[q] == NIL) head_m[q] = 6'(r.pid);
                    else next_m[tail_m[q]] = 6'(r.pid);
                    tail_m[q] = 6'(r.pid);
                    waiting_m[r.pid] = 1'b1;
                    sem_of[r.pid] = r.sem_index;
                    lvl_of[r.pid] = r.priority_req;
                    res.status = ST_BLOCKED;
                end
            end
        end
        else if (r.req_type == REQ_SIGNAL)
        begin
            if (r.sem_index < NSEM)
            begin
                for (int l = NLVL - 1; l >= 0 && !res.woken_valid; l--)
                begin
                    q = r.sem_index * NLVL + l;
                    if (head_m[q] != NIL)
                    begin
                        res.woken_valid = 1'b1;
                        res.woken_pid = head_m[q][4:0];
                        unlink_waiter(head_m[q]);
                    end
                end
                if (!res.woken_valid && count_m[r.sem_index] != COUNT_TOP)
                    count_m[r.sem_index]++;
                res.status = ST_OK;
            end
        end
        else if (r.req_type == REQ_CANCEL)
        begin
            if (r.pid < NSLOT && waiting_m[r.pid])
            begin
                unlink_waiter(r.pid);
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic sem_req_t make_req(logic [1:0] t, int s, int p, int l);
        sem_req_t r;
        r.req_type = t;
        r.sem_index = 8'(s);
        r.pid = 5'(p);
        r.priority_req = 2'(l);
        return r;
    endfunction

    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (!in_valid || in_fire)
        begin
            if (in_valid && in_fire)
            begin
                void'(pending_reqs.pop_front());
            end
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                sem_req_t r;
                r = pending_reqs[0];
                in_valid <= 1'b1;
                req_type <= r.req_type;
                sem_index <= r.sem_index;
                pid <= r.pid;
                priority_req <= r.priority_req;
                in_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else if (hold_off)
        begin
            out_stall <= 1'b1;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap <= out_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            out_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_resps.push_back(predict_semaphore(
                    make_req(req_type, sem_index, pid, priority_req)));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_resps.size() == 0)
                begin
                    $display("%0t: unexpected beat status=%0d woken=%0d/%0d", $time,
                             status, woken_valid, woken_pid);
                    failed = 1'b1;
                end
                else
                begin
                    sem_resp_t e;
                    e = expected_resps.pop_front();
                    if (status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, status);
                        failed = 1'b1;
                    end
                    if (woken_valid !== e.woken_valid)
                    begin
                        $display("%0t: woken_valid expected %0d actual %0d", $time,
                                 e.woken_valid, woken_valid);
                        failed = 1'b1;
                    end
                    if (woken_pid !== e.woken_pid)
                    begin
                        $display("%0t: woken_pid expected %0d actual %0d", $time,
                                 e.woken_pid, woken_pid);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int k;
        int s;
        rst_n = 1'b0;
        failed = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        req_type = REQ_WAIT;
        sem_index = '0;
        pid = '0;
        priority_req = '0;
        for (int i = 0; i < NSEM; i++) count_m[i] = '0;
        for (int i = 0; i < NQ; i++)
        begin
            head_m[i] = NIL;
            tail_m[i] = NIL;
        end
        for (int i = 0; i < NSLOT; i++)
        begin
            next_m[i] = '0;
            prev_m[i] = '0;
            waiting_m[i] = 1'b0;
            sem_of[i] = 0;
            lvl_of[i] = 0;
        end

        pending_reqs.push_back(make_req(REQ_WAIT, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_WAIT, 0, 31, 3));
        pending_reqs.push_back(make_req(REQ_WAIT, 0, 5, 0));
        pending_reqs.push_back(make_req(REQ_WAIT, 0, 6, 0));
        pending_reqs.push_back(make_req(REQ_WAIT, 0, 0, 1));
        pending_reqs.push_back(make_req(REQ_CANCEL, 255, 5, 3));
        pending_reqs.push_back(make_req(REQ_CANCEL, 0, 5, 0));
        pending_reqs.push_back(make_req(REQ_WAIT, 255, 7, 0));
        pending_reqs.push_back(make_req(REQ_SIGNAL, 2, 0, 0));
        pending_reqs.push_back(make_req(REQ_BAD, 0, 1, 1));
        pending_reqs.push_back(make_req(REQ_SIGNAL, 0, 31, 3));
        pending_reqs.push_back(make_req(REQ_SIGNAL, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_SIGNAL, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_SIGNAL, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_WAIT, 0, 9, 2));
        pending_reqs.push_back(make_req(REQ_WAIT, 1, 10, 2));
        pending_reqs.push_back(make_req(REQ_SIGNAL, 1, 0, 0));
        pending_reqs.push_back(make_req(REQ_WAIT, 1, 10, 2));
        pending_reqs.push_back(make_req(REQ_WAIT, 1, 10, 1));
        pending_reqs.push_back(make_req(REQ_CANCEL, 0, 10, 0));
        pending_reqs.push_back(make_req(REQ_CANCEL, 0, 10, 0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 540; i++)
        begin
            k = $urandom_range(0, 99);
            s = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, NSEM - 1);
            if (k < 45)
                pending_reqs.push_back(make_req(REQ_WAIT, s, $urandom_range(0, 31),
                                                $urandom_range(0, 3)));
            else if (k < 80)
                pending_reqs.push_back(make_req(REQ_SIGNAL, s, $urandom_range(0, 31),
                                                $urandom_range(0, 3)));
            else if (k < 96)
                pending_reqs.push_back(make_req(REQ_CANCEL, $urandom_range(0, 255),
                                                $urandom_range(0, 31),
                                                $urandom_range(0, 3)));
            else
                pending_reqs.push_back(make_req(REQ_BAD, $urandom_range(0, 255),
                                                $urandom_range(0, 31),
                                                $urandom_range(0, 3)));
            if (i == 200)
            begin
                while (pending_reqs.size() > 20) @(posedge clk);
                hold_off = 1'b1;
                repeat (150) @(posedge clk);
                hold_off = 1'b0;
            end
        end
        while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
